[src/mtrc_pkg.sv]
// ----------------------------------------------------------------------------
// mtrc_pkg - shared types and constants of the memory read-back checker
// Request, command and result types, register indexes, reset values and the
// xorshift32 step used by the expected-word generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mtrc_pkg;

  // Default depth of the fail log
  localparam int unsigned MAX_LOGGED_FAILS = 16;

  // Largest pass length in words
  localparam logic [22:0] WORD_COUNT_MAX = 23'd4194304;

  // Queue depths between the parts
  localparam int unsigned REQ_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 4;

  // Register reset values
  localparam logic        TEST_MODE_RST    = 1'b0;
  localparam logic [31:0] FILL_PATTERN_RST = 32'h0000_0000;
  localparam logic [31:0] PRNG_SEED_RST    = 32'h0000_0001;
  localparam logic [31:0] BASE_ADDRESS_RST = 32'h0000_0000;
  localparam logic [22:0] WORD_COUNT_RST   = 23'd2097152;

  // Request type codes on the input port
  localparam logic [1:0] REQ_CHECK    = 2'd0;
  localparam logic [1:0] REQ_LOG_READ = 2'd1;
  localparam logic [1:0] REQ_CLEAR    = 2'd2;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_TEST_MODE    = 3'd0,
    CFG_FILL_PATTERN = 3'd1,
    CFG_PRNG_SEED    = 3'd2,
    CFG_BASE_ADDRESS = 3'd3,
    CFG_WORD_COUNT   = 3'd4
  } cfg_idx_e;

  // Decoded operation handed from front to back
  typedef enum logic [1:0] {
    OP_CHECK    = 2'd0,
    OP_LOG_READ = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] read_word;
    logic [3:0]  log_index;
  } req_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] read_word;
    logic [3:0]  log_index;
  } cmd_t;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] expected;
    logic [31:0] got;
  } log_t;

  typedef struct packed {
    logic        mismatch;
    logic [31:0] word_address;
    logic [31:0] expected_word;
    logic [31:0] got_word;
    logic [31:0] error_count;
    logic [4:0]  fail_count;
    logic [31:0] bad_bits;
    logic [31:0] bad_bits_odd;
    logic [31:0] bad_bits_even;
  } res_t;

  // One xorshift32 step, shifts 13, 17, 5
  function automatic logic [31:0] next_xs(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    a = v ^ (v << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

`default_nettype wire

[src/mtrc_front.sv]
// ----------------------------------------------------------------------------
// mtrc_front - request intake
// Accepts request transactions, decodes the request type into an operation
// and holds the commands in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire mtrc_pkg::req_t  req_i,
  output logic                 full_o,
  output logic                 cmd_valid_o,
  output mtrc_pkg::cmd_t       cmd_o,
  input  wire logic            cmd_take_i
);

  localparam int unsigned PtrW = $clog2(mtrc_pkg::REQ_DEPTH);
  localparam int unsigned CntW = $clog2(mtrc_pkg::REQ_DEPTH + 1);

  mtrc_pkg::cmd_t            queue_q [mtrc_pkg::REQ_DEPTH];
  logic [PtrW-1:0]           wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  mtrc_pkg::cmd_t            cmd_in;
  logic                      enq, deq;

  // Classify the incoming request
  always_comb begin
    cmd_in.read_word = req_i.read_word;
    cmd_in.log_index = req_i.log_index;
    case (req_i.req_type)
      mtrc_pkg::REQ_CHECK:    cmd_in.op = mtrc_pkg::OP_CHECK;
      mtrc_pkg::REQ_LOG_READ: cmd_in.op = mtrc_pkg::OP_LOG_READ;
      mtrc_pkg::REQ_CLEAR:    cmd_in.op = mtrc_pkg::OP_CLEAR;
      default:                cmd_in.op = mtrc_pkg::OP_NONE;
    endcase
  end

  assign full_o      = (cnt_q == CntW'(mtrc_pkg::REQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign enq         = push_i & ~full_o;
  assign deq         = cmd_take_i & cmd_valid_o;

  // Queue pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (enq) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(mtrc_pkg::REQ_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (deq) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(mtrc_pkg::REQ_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({enq, deq})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage, no reset
  always_ff @(posedge clk_i) begin
    if (enq) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

[src/mtrc_back.sv]
// ----------------------------------------------------------------------------
// mtrc_back - check engine and result queue
// Holds configuration and test state, generates the expected word, compares,
// accumulates counts and masks, keeps the fail log memory and queues results.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrc_back #(
  parameter int unsigned MaxLoggedFails = mtrc_pkg::MAX_LOGGED_FAILS
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_valid_i,
  input  wire logic [2:0]      cfg_index_i,
  input  wire logic [31:0]     cfg_data_i,
  input  wire logic            cmd_valid_i,
  input  wire mtrc_pkg::cmd_t  cmd_i,
  output logic                 cmd_take_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output mtrc_pkg::res_t       res_o
);

  localparam int unsigned LogIw  = (MaxLoggedFails > 1) ? $clog2(MaxLoggedFails) : 1;
  localparam int unsigned FcW    = $clog2(MaxLoggedFails + 1);
  localparam int unsigned RPtrW  = $clog2(mtrc_pkg::RES_DEPTH);
  localparam int unsigned RCntW  = $clog2(mtrc_pkg::RES_DEPTH + 1);

  // Configuration registers
  logic        test_mode_q;
  logic [31:0] fill_q, seed_q, base_q;
  logic [22:0] wcount_q;

  // Test state
  logic [21:0]    widx_q, widx_d;
  logic [31:0]    gen_q, gen_d;
  logic [31:0]    err_q, err_d;
  logic [FcW-1:0] fails_q, fails_d;
  logic [31:0]    mask_all_q, mask_all_d;
  logic [31:0]    mask_odd_q, mask_odd_d;
  logic [31:0]    mask_even_q, mask_even_d;

  // Fail log memory
  mtrc_pkg::log_t log_mem [MaxLoggedFails];
  mtrc_pkg::log_t log_rd_q;
  mtrc_pkg::log_t log_wdata;
  logic           log_we, log_re;
  logic [LogIw-1:0] log_waddr, log_raddr;

  // Execute stage register
  logic           s1_v_q;
  logic           s1_hit_q, s1_hit_d;
  mtrc_pkg::res_t s1_res_q, s1_res_d;

  // Result queue
  mtrc_pkg::res_t   rq_q [mtrc_pkg::RES_DEPTH];
  logic [RPtrW-1:0] rq_wr_q, rq_rd_q;
  logic [RCntW-1:0] rq_cnt_q;
  mtrc_pkg::res_t   rq_in;
  logic             rq_pop;

  logic        take;
  logic        cfg_restart;
  logic [31:0] seed_eff, seed_load;
  logic [22:0] pass_len, widx_inc;
  logic [31:0] chk_addr, chk_exp, chk_diff, gen_nx;
  logic        chk_mis, log_hit;

  // Credit covers the entry in the execute stage
  assign take = cmd_valid_i &
                (({1'b0, rq_cnt_q} + (RCntW + 1)'(s1_v_q)) < (RCntW + 1)'(mtrc_pkg::RES_DEPTH));
  assign cmd_take_o = take;

  // Seed used at restart, zero counts as one
  always_comb begin
    cfg_restart = 1'b0;
    seed_eff    = seed_q;
    if (cfg_valid_i) begin
      case (mtrc_pkg::cfg_idx_e'(cfg_index_i))
        mtrc_pkg::CFG_TEST_MODE,
        mtrc_pkg::CFG_FILL_PATTERN,
        mtrc_pkg::CFG_BASE_ADDRESS,
        mtrc_pkg::CFG_WORD_COUNT:   cfg_restart = 1'b1;
        mtrc_pkg::CFG_PRNG_SEED: begin
          cfg_restart = 1'b1;
          seed_eff    = cfg_data_i;
        end
        default:                    cfg_restart = 1'b0;
      endcase
    end
    seed_load = (seed_eff == '0) ? 32'd1 : seed_eff;
  end

  // Pass length with zero and oversize clamped
  always_comb begin
    if (wcount_q == '0) begin
      pass_len = 23'd1;
    end else if (wcount_q > mtrc_pkg::WORD_COUNT_MAX) begin
      pass_len = mtrc_pkg::WORD_COUNT_MAX;
    end else begin
      pass_len = wcount_q;
    end
  end

  // Check datapath
  assign gen_nx   = mtrc_pkg::next_xs(gen_q);
  assign chk_addr = base_q + 32'({widx_q, 2'b00});
  assign chk_exp  = test_mode_q ? gen_nx : fill_q;
  assign chk_diff = chk_exp ^ cmd_i.read_word;
  assign chk_mis  = (chk_diff != '0);
  assign widx_inc = {1'b0, widx_q} + 23'd1;
  assign log_hit  = (8'(cmd_i.log_index) < 8'(fails_q)) &&
                    (8'(cmd_i.log_index) < 8'(MaxLoggedFails));

  // Command execution
  always_comb begin
    widx_d      = widx_q;
    gen_d       = gen_q;
    err_d       = err_q;
    fails_d     = fails_q;
    mask_all_d  = mask_all_q;
    mask_odd_d  = mask_odd_q;
    mask_even_d = mask_even_q;
    log_we      = 1'b0;
    log_waddr   = LogIw'(fails_q);
    log_wdata   = '{address: chk_addr, expected: chk_exp, got: cmd_i.read_word};
    log_re      = 1'b0;
    log_raddr   = LogIw'(cmd_i.log_index);
    s1_hit_d    = 1'b0;
    s1_res_d    = '0;

    if (take) begin
      case (cmd_i.op)
        mtrc_pkg::OP_CHECK: begin
          s1_res_d.mismatch      = chk_mis;
          s1_res_d.word_address  = chk_addr;
          s1_res_d.expected_word = chk_exp;
          s1_res_d.got_word      = cmd_i.read_word;
          if (test_mode_q) begin
            gen_d = gen_nx;
          end
          if (chk_mis) begin
            if (err_q != '1) begin
              err_d = err_q + 32'd1;
            end
            mask_all_d = mask_all_q | chk_diff;
            if (chk_addr[2]) begin
              mask_odd_d = mask_odd_q | chk_diff;
            end else begin
              mask_even_d = mask_even_q | chk_diff;
            end
            if (fails_q < FcW'(MaxLoggedFails)) begin
              log_we  = 1'b1;
              fails_d = fails_q + FcW'(1);
            end
          end
          if (widx_inc >= pass_len) begin
            widx_d = '0;
            gen_d  = seed_load;
          end else begin
            widx_d = widx_inc[21:0];
          end
        end
        mtrc_pkg::OP_LOG_READ: begin
          s1_hit_d = log_hit;
          log_re   = log_hit;
        end
        mtrc_pkg::OP_CLEAR: begin
          err_d       = '0;
          fails_d     = '0;
          mask_all_d  = '0;
          mask_odd_d  = '0;
          mask_even_d = '0;
          widx_d      = '0;
          gen_d       = seed_load;
        end
        default: begin
        end
      endcase
      s1_res_d.error_count   = err_d;
      s1_res_d.fail_count    = 5'(fails_d);
      s1_res_d.bad_bits      = mask_all_d;
      s1_res_d.bad_bits_odd  = mask_odd_d;
      s1_res_d.bad_bits_even = mask_even_d;
    end

    // Register write restarts the pass
    if (cfg_restart) begin
      widx_d = '0;
      gen_d  = seed_load;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_mode_q <= mtrc_pkg::TEST_MODE_RST;
      fill_q      <= mtrc_pkg::FILL_PATTERN_RST;
      seed_q      <= mtrc_pkg::PRNG_SEED_RST;
      base_q      <= mtrc_pkg::BASE_ADDRESS_RST;
      wcount_q    <= mtrc_pkg::WORD_COUNT_RST;
    end else if (cfg_valid_i) begin
      case (mtrc_pkg::cfg_idx_e'(cfg_index_i))
        mtrc_pkg::CFG_TEST_MODE:    test_mode_q <= cfg_data_i[0];
        mtrc_pkg::CFG_FILL_PATTERN: fill_q      <= cfg_data_i;
        mtrc_pkg::CFG_PRNG_SEED:    seed_q      <= cfg_data_i;
        mtrc_pkg::CFG_BASE_ADDRESS: base_q      <= cfg_data_i;
        mtrc_pkg::CFG_WORD_COUNT:   wcount_q    <= cfg_data_i[22:0];
        default: begin
        end
      endcase
    end
  end

  // Test state and execute stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q      <= '0;
      gen_q       <= 32'd1;
      err_q       <= '0;
      fails_q     <= '0;
      mask_all_q  <= '0;
      mask_odd_q  <= '0;
      mask_even_q <= '0;
      s1_v_q      <= 1'b0;
      s1_hit_q    <= 1'b0;
    end else begin
      widx_q      <= widx_d;
      gen_q       <= gen_d;
      err_q       <= err_d;
      fails_q     <= fails_d;
      mask_all_q  <= mask_all_d;
      mask_odd_q  <= mask_odd_d;
      mask_even_q <= mask_even_d;
      s1_v_q      <= take;
      s1_hit_q    <= s1_hit_d;
    end
  end

  // Execute stage payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_res_q <= s1_res_d;
    end
  end

  // Fail log memory, registered read
  always_ff @(posedge clk_i) begin
    if (log_we) begin
      log_mem[log_waddr] <= log_wdata;
    end
    if (log_re) begin
      log_rd_q <= log_mem[log_raddr];
    end
  end

  // Merge log data into the result
  always_comb begin
    rq_in = s1_res_q;
    if (s1_hit_q) begin
      rq_in.word_address  = log_rd_q.address;
      rq_in.expected_word = log_rd_q.expected;
      rq_in.got_word      = log_rd_q.got;
    end
  end

  // Result queue
  assign empty_o = (rq_cnt_q == '0);
  assign rq_pop  = pop_i & ~empty_o;
  assign res_o   = rq_q[rq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= '0;
      rq_rd_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      if (s1_v_q) begin
        rq_wr_q <= rq_wr_q + RPtrW'(1);
      end
      if (rq_pop) begin
        rq_rd_q <= rq_rd_q + RPtrW'(1);
      end
      case ({s1_v_q, rq_pop})
        2'b10:   rq_cnt_q <= rq_cnt_q + RCntW'(1);
        2'b01:   rq_cnt_q <= rq_cnt_q - RCntW'(1);
        default: rq_cnt_q <= rq_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      rq_q[rq_wr_q] <= rq_in;
    end
  end

endmodule

`default_nettype wire

[src/memory_test_readback_checker.sv]
// A request passes the request queue, the execute stage register and the result queue before its result is popped.
// Throughput: one request per cycle while the result queue has room, set by the check stage.
// A fail log read uses one registered read of the log memory in the stage after.
// Reset: asynchronous, active low; registers take their defaults, counts and
// masks clear, the log memory keeps its contents and is not swept.
// ----------------------------------------------------------------------------
// memory_test_readback_checker - memory read-back checker
// Compares read-back words against a fixed pattern or xorshift32 stream,
// counts and logs mismatches and answers log reads and clears.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_test_readback_checker #(
  parameter int unsigned MaxLoggedFails = mtrc_pkg::MAX_LOGGED_FAILS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request queue side
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] read_word_i,
  input  wire logic [3:0]  log_index_i,
  // Result queue side
  output logic             empty,
  input  wire logic        pop,
  output logic             mismatch_o,
  output logic [31:0]      word_address_o,
  output logic [31:0]      expected_word_o,
  output logic [31:0]      got_word_o,
  output logic [31:0]      error_count_o,
  output logic [4:0]       fail_count_o,
  output logic [31:0]      bad_bits_o,
  output logic [31:0]      bad_bits_odd_o,
  output logic [31:0]      bad_bits_even_o,
  // Configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  mtrc_pkg::req_t req;
  mtrc_pkg::cmd_t cmd;
  mtrc_pkg::res_t res;
  logic           cmd_valid, cmd_take;

  assign req = '{req_type: req_type_i, read_word: read_word_i, log_index: log_index_i};

  // Registers always take a write
  assign cfg_ready_o = 1'b1;

  mtrc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .req_i       (req),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  mtrc_back #(
    .MaxLoggedFails (MaxLoggedFails)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign mismatch_o      = res.mismatch;
  assign word_address_o  = res.word_address;
  assign expected_word_o = res.expected_word;
  assign got_word_o      = res.got_word;
  assign error_count_o   = res.error_count;
  assign fail_count_o    = res.fail_count;
  assign bad_bits_o      = res.bad_bits;
  assign bad_bits_odd_o  = res.bad_bits_odd;
  assign bad_bits_even_o = res.bad_bits_even;

endmodule

`default_nettype wire
